// File: src/ppc_pkg.sv
package ppc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int MUL_PHASES   = 4;

  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int ANG_W   = 32;
  localparam int CW      = 34;
  localparam int PROD_W  = POS_W + CW;
  localparam int ACC_W   = PROD_W + 1;
  localparam int FRAC_W  = 30;
  localparam int RX_W    = ACC_W - FRAC_W;
  localparam int SUM_W   = RX_W + 1;

  localparam logic signed [CW-1:0]    CORDIC_GAIN = CW'(652032874);
  localparam logic signed [ACC_W-1:0] ACC_INIT    = ACC_W'(536870912);

  typedef struct packed {
    logic                     mode;
    logic signed [POS_W-1:0]  delta_x;
    logic signed [POS_W-1:0]  delta_y;
    logic signed [HEAD_W-1:0] delta_heading;
  } ppc_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [HEAD_W-1:0] out_heading;
    logic                     saturated;
  } ppc_out_t;

  typedef struct packed {
    logic              capture;
    logic              step;
    logic              mul_issue;
    logic              commit;
    logic [STEP_W-1:0] idx;
  } ppc_cmd_t;

  typedef struct packed {
    logic in_load;
  } ppc_sts_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/ppc_ctrl.sv
module ppc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  input  ppc_pkg::ppc_sts_t sts,
  output logic              in_stall,
  output logic              out_valid,
  output ppc_pkg::ppc_cmd_t cmd
);
  import ppc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROT   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.idx       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = sts.in_load ? S_FIN : S_ROT;
        end
      end
      S_ROT: begin
        cmd.step = 1'b1;
        if (cnt_r == STEP_W'(CORDIC_ITERS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_issue = 1'b1;
        if (cnt_r == STEP_W'(MUL_PHASES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/ppc_datapath.sv
module ppc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  ppc_pkg::ppc_cmd_t cmd,
  input  ppc_pkg::ppc_in_t  in_data,
  output ppc_pkg::ppc_sts_t sts,
  output ppc_pkg::ppc_out_t out_data
);
  import ppc_pkg::*;

  logic                     mode_r;
  logic signed [POS_W-1:0]  dx_r, dy_r;
  logic signed [HEAD_W-1:0] dh_r;
  logic signed [CW-1:0]     cx_r, cy_r, cz_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     prod_vld_r;
  logic [1:0]               prod_sel_r;
  logic signed [ACC_W-1:0]  accx_r, accy_r;
  logic signed [POS_W-1:0]  pose_x_r, pose_y_r;
  logic signed [HEAD_W-1:0] pose_th_r;
  ppc_out_t                 out_r, out_nxt;

  // CORDIC start: headings in the left half-plane begin at (-K, 0) with pi added.
  logic [ANG_W-1:0]     ang;
  logic                 flip;
  logic signed [CW-1:0] z_init, x_init;

  assign ang    = {pose_th_r, 16'h0000};
  assign flip   = ang[ANG_W-1] ^ ang[ANG_W-2];
  assign z_init = CW'($signed(ang ^ {flip, {(ANG_W-1){1'b0}}}));
  assign x_init = flip ? -CORDIC_GAIN : CORDIC_GAIN;

  logic signed [CW-1:0] xs, ys, at;

  assign xs = cx_r >>> cmd.idx;
  assign ys = cy_r >>> cmd.idx;
  assign at = CW'($signed({1'b0, atan_entry(cmd.idx)}));

  // One shared multiplier: dx*c, dy*s, dx*s, dy*c in that order.
  logic [1:0]               mul_sel;
  logic signed [POS_W-1:0]  mul_a;
  logic signed [CW-1:0]     mul_b;

  assign mul_sel  = cmd.idx[1:0];
  assign mul_a    = mul_sel[0] ? dy_r : dx_r;
  assign mul_b    = (mul_sel[0] == mul_sel[1]) ? cx_r : cy_r;
  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  logic signed [RX_W-1:0]  rx, ry;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                    ovf_x, ovf_y;
  logic signed [POS_W-1:0] clip_x, clip_y;

  assign rx    = RX_W'(accx_r >>> FRAC_W);
  assign ry    = RX_W'(accy_r >>> FRAC_W);
  assign sum_x = SUM_W'(pose_x_r) + SUM_W'(rx);
  assign sum_y = SUM_W'(pose_y_r) + SUM_W'(ry);
  assign ovf_x = |sum_x[SUM_W-1:POS_W-1] && !(&sum_x[SUM_W-1:POS_W-1]);
  assign ovf_y = |sum_y[SUM_W-1:POS_W-1] && !(&sum_y[SUM_W-1:POS_W-1]);

  always_comb begin
    if (ovf_x) begin
      clip_x = sum_x[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      clip_x = sum_x[POS_W-1:0];
    end
    if (ovf_y) begin
      clip_y = sum_y[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      clip_y = sum_y[POS_W-1:0];
    end
    if (mode_r) begin
      out_nxt.out_x       = dx_r;
      out_nxt.out_y       = dy_r;
      out_nxt.out_heading = dh_r;
      out_nxt.saturated   = 1'b0;
    end else begin
      out_nxt.out_x       = clip_x;
      out_nxt.out_y       = clip_y;
      out_nxt.out_heading = pose_th_r + dh_r;
      out_nxt.saturated   = ovf_x || ovf_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r   <= '0;
      pose_y_r   <= '0;
      pose_th_r  <= '0;
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_issue;
      if (cmd.commit) begin
        pose_x_r  <= out_nxt.out_x;
        pose_y_r  <= out_nxt.out_y;
        pose_th_r <= out_nxt.out_heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_data.mode;
      dx_r   <= in_data.delta_x;
      dy_r   <= in_data.delta_y;
      dh_r   <= in_data.delta_heading;
      cx_r   <= x_init;
      cy_r   <= '0;
      cz_r   <= z_init;
      accx_r <= ACC_INIT;
      accy_r <= ACC_INIT;
    end else if (cmd.step) begin
      if (!cz_r[CW-1]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.mul_issue) begin
      prod_r     <= prod_nxt;
      prod_sel_r <= mul_sel;
    end
    if (prod_vld_r) begin
      unique case (prod_sel_r)
        2'd0:    accx_r <= accx_r + ACC_W'(prod_r);
        2'd1:    accx_r <= accx_r - ACC_W'(prod_r);
        default: accy_r <= accy_r + ACC_W'(prod_r);
      endcase
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign sts.in_load = in_data.mode;
  assign out_data    = out_r;

endmodule

// File: src/planar_pose_composer_core.sv
// Channel  | Ports                          | Transaction
// ---------+--------------------------------+----------------------------------------------
// input    | in_valid, in_stall, in_data    | mode, delta_x, delta_y, delta_heading
// result   | out_valid, out_stall, out_data | out_x, out_y, out_heading, saturated
//
// A compose transaction runs 16 CORDIC rotation steps, four passes of one shared 32x34
// multiplier, an accumulate drain and the final add/clip; its result is registered at the
// commit, and the next transaction is taken after that, back in the idle state.
// A load transaction goes straight to the final commit, which registers its result.
// Reset (rst_n low, synchronous) clears the pose to zero and empties the result register.
// A waiting result never blocks the input; a stalled one only holds back the next commit.
module planar_pose_composer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ppc_pkg::ppc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ppc_pkg::ppc_out_t out_data
);
  import ppc_pkg::*;

  ppc_cmd_t cmd;
  ppc_sts_t sts;

  // The controller sequences the rotation steps, the multiplier passes and the commit
  // of the new pose, which writes the pose registers and the result register together.
  ppc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the pose, the CORDIC registers, the multiplier and accumulators.
  ppc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

  // Once a transaction is taken, the block is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // A load taken with an empty result register shows the loaded heading after its commit.
  a_load_heading: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode && !out_valid
    |=> ##1 (out_valid && out_data.out_heading == $past(in_data.delta_heading, 2)))
    else $error("load result missing or heading wrong");

  // A clipped result must sit at a limit of the signed 32-bit range.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.out_x == 32'sh7FFFFFFF || out_data.out_x == 32'sh80000000 ||
       out_data.out_y == 32'sh7FFFFFFF || out_data.out_y == 32'sh80000000))
    else $error("saturation flag without a clipped coordinate");

endmodule

// File: test/testbench.sv
module testbench;

  import ppc_pkg::*;

  // Settle time after the last result: longer than a compose or a load
  // transaction takes from acceptance to its result.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_TXNS   = 600;
  localparam int HOLD_CYCLES   = 300;

  localparam logic MODE_COMPOSE = 1'b0;
  localparam logic MODE_LOAD    = 1'b1;

  localparam logic signed [31:0] Q_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE  = 32'sh00010000;
  localparam logic signed [15:0] H_MIN  = 16'sh8000;
  localparam logic signed [15:0] H_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] H_QTR  = 16'sh4000;

  // CORDIC constants: the gain is in Q2.30, and the rounding half is applied
  // before the 30-bit shift back to Q16.16.
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_Q30 = 64'sd536870912;
  // The iterations stop at the end of the arctangent table, whatever the step count.
  localparam int ROT_STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  // Arctangent of 2^-i as a 32-bit binary angle. Entry 0 sits in the top word.
  localparam logic [24*32-1:0] ARCTAN_Q32 = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    ppc_in_t  txn;
    bit       typed;
    ppc_out_t res;
  } plan_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  ppc_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  ppc_out_t out_data;

  // The bench's own copy of the pose.
  logic signed [31:0] est_x = '0;
  logic signed [31:0] est_y = '0;
  logic        [15:0] est_heading = '0;

  ppc_out_t    pending_poses [$];
  plan_row_t   plan [$];
  int          err_count    = 0;
  int unsigned cycle_count  = 0;
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  logic        hold_go      = 1'b0;
  logic        long_hold    = 1'b0;
  ppc_out_t    want;

  planar_pose_composer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Rotation-mode CORDIC. Headings in the second and third quadrants start
  // from the negated gain, and the angle is turned through half a turn.
  function automatic void heading_cos_sin(input logic [15:0] heading,
                                          output longint cos_q30, output longint sin_q30);
    logic [31:0] ang;
    longint      cx, cy, resid, xs, ys, step_ang;
    int          i;
    ang = {heading, 16'h0000};
    cx  = GAIN_Q30;
    cy  = 0;
    if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
      cx      = -cx;
      ang[31] = ~ang[31];
    end
    resid = longint'($signed(ang));
    for (i = 0; i < ROT_STEPS; i++) begin
      xs       = cx >>> i;
      ys       = cy >>> i;
      step_ang = longint'(ARCTAN_Q32[(23 - i) * 32 +: 32]);
      if (resid >= 0) begin
        cx    = cx - ys;
        cy    = cy + xs;
        resid = resid - step_ang;
      end else begin
        cx    = cx + ys;
        cy    = cy - xs;
        resid = resid + step_ang;
      end
    end
    cos_q30 = cx;
    sin_q30 = cy;
  endfunction

  function automatic logic signed [31:0] clip_q16(input longint v, output logic hit);
    hit = 1'b1;
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    hit = 1'b0;
    return v[31:0];
  endfunction

  // Advances the pose by one transaction and returns the pose that the core
  // should report for it.
  function automatic ppc_out_t advance_pose(input ppc_in_t d);
    ppc_out_t r;
    longint   cq, sq, rx, ry;
    logic     hit_x, hit_y;
    hit_x = 1'b0;
    hit_y = 1'b0;
    if (d.mode == MODE_LOAD) begin
      est_x       = d.delta_x;
      est_y       = d.delta_y;
      est_heading = d.delta_heading;
    end else begin
      heading_cos_sin(est_heading, cq, sq);
      rx = (longint'($signed(d.delta_x)) * cq - longint'($signed(d.delta_y)) * sq
            + HALF_Q30) >>> 30;
      ry = (longint'($signed(d.delta_x)) * sq + longint'($signed(d.delta_y)) * cq
            + HALF_Q30) >>> 30;
      est_x       = clip_q16(longint'(est_x) + rx, hit_x);
      est_y       = clip_q16(longint'(est_y) + ry, hit_y);
      est_heading = est_heading + d.delta_heading;
    end
    r.out_x       = est_x;
    r.out_y       = est_y;
    r.out_heading = est_heading;
    r.saturated   = hit_x | hit_y;
    return r;
  endfunction

  function automatic void plan_row(input logic mode, input logic signed [31:0] dx,
                                   input logic signed [31:0] dy, input logic signed [15:0] dh,
                                   input bit typed = 1'b0,
                                   input logic signed [31:0] ex = '0,
                                   input logic signed [31:0] ey = '0,
                                   input logic signed [15:0] eh = '0,
                                   input logic es = 1'b0);
    plan_row_t row;
    row.txn.mode          = mode;
    row.txn.delta_x       = dx;
    row.txn.delta_y       = dy;
    row.txn.delta_heading = dh;
    row.typed             = typed;
    row.res.out_x         = ex;
    row.res.out_y         = ey;
    row.res.out_heading   = eh;
    row.res.saturated     = es;
    plan.push_back(row);
  endfunction

  // Offsets of every scale: a few extremes, some full-range words, and mostly
  // values shifted down so that the pose wanders without clipping all the time.
  function automatic logic signed [31:0] random_offset();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return Q_MIN;
          1:       return Q_MAX;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
      1, 2:    return $urandom;
      default: return $signed($urandom) >>> $urandom_range(31, 6);
    endcase
  endfunction

  function automatic ppc_in_t random_txn();
    ppc_in_t t;
    t.mode          = ($urandom_range(7) == 0) ? MODE_LOAD : MODE_COMPOSE;
    t.delta_x       = random_offset();
    t.delta_y       = random_offset();
    t.delta_heading = 16'($urandom_range(65535));
    return t;
  endfunction

  // Offers one transaction, with the sender's idle cycles first, and waits until
  // the core takes it. The expected pose is queued at the accepting edge.
  task automatic send_txn(input ppc_in_t item, input bit typed, input ppc_out_t fixed_res);
    ppc_out_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_pose(item);
    pending_poses.push_back(typed ? fixed_res : pred);
  endtask

  // Withdraws the sender and waits until every queued pose has come back.
  task automatic settle_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      err_count++;
    end
  endtask

  // The receiver stalls at random, and for one long stretch it stalls without
  // a break, so that the core backs up and stalls its input.
  always @(negedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < recv_gap_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // Result checker: every result transaction must match the oldest queued pose.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        $error("result transaction with no pose expected: x %0d y %0d heading %0d",
               $signed(out_data.out_x), $signed(out_data.out_y),
               $signed(out_data.out_heading));
        err_count++;
      end else begin
        want = pending_poses.pop_front();
        check_field("out_x", $signed(want.out_x), $signed(out_data.out_x));
        check_field("out_y", $signed(want.out_y), $signed(out_data.out_y));
        check_field("out_heading", $signed(want.out_heading), $signed(out_data.out_heading));
        check_field("saturated", longint'(want.saturated), longint'(out_data.saturated));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("planar_pose_composer_core regression: fail");
      $finish;
    end
  end

  initial begin
    // Directed table. A zero delta straight after reset must leave the pose at
    // zero.
    plan_row(MODE_COMPOSE, '0, '0, '0, 1'b1, '0, '0, '0, 1'b0);
    plan_row(MODE_COMPOSE, Q_ONE, '0, '0);
    // Loads return the delta unchanged, with the saturation flag clear.
    plan_row(MODE_LOAD, Q_MIN, Q_MAX, H_MIN, 1'b1, Q_MIN, Q_MAX, H_MIN, 1'b0);
    plan_row(MODE_LOAD, Q_MAX, Q_MIN, '0, 1'b1, Q_MAX, Q_MIN, '0, 1'b0);
    // At heading zero, a full-scale step outwards clips both coordinates.
    plan_row(MODE_COMPOSE, Q_MAX, Q_MIN, '0, 1'b1, Q_MAX, Q_MIN, '0, 1'b1);
    plan_row(MODE_COMPOSE, Q_MIN, Q_MAX, '0);
    // Two quarter turns make exactly half a turn, which reads as the most
    // negative heading.
    plan_row(MODE_LOAD, '0, '0, H_QTR, 1'b1, '0, '0, H_QTR, 1'b0);
    plan_row(MODE_COMPOSE, '0, '0, H_QTR, 1'b1, '0, '0, H_MIN, 1'b0);
    plan_row(MODE_COMPOSE, Q_ONE, '0, '0);
    plan_row(MODE_COMPOSE, '0, Q_ONE, -16'sd16384);
    plan_row(MODE_LOAD, '0, '0, -16'sd1, 1'b1, '0, '0, -16'sd1, 1'b0);
    plan_row(MODE_COMPOSE, 32'sh00100000, -32'sh00100000, 16'sd1);
    plan_row(MODE_COMPOSE, '0, '0, H_MIN);
    plan_row(MODE_COMPOSE, Q_MAX, Q_MAX, H_MAX);
    plan_row(MODE_COMPOSE, Q_MIN, Q_MIN, H_MIN);
    plan_row(MODE_LOAD, -32'sd1, -32'sd1, 16'sd8192, 1'b1, -32'sd1, -32'sd1, 16'sd8192, 1'b0);
    plan_row(MODE_COMPOSE, 32'sd6553600, -32'sd3276800, 16'sd24576);
    plan_row(MODE_LOAD, Q_MAX, Q_MAX, 16'sd8192, 1'b1, Q_MAX, Q_MAX, 16'sd8192, 1'b0);
    plan_row(MODE_COMPOSE, Q_MAX, Q_MAX, '0);
    plan_row(MODE_COMPOSE, Q_MIN, Q_MIN, 16'sd24576);
    plan_row(MODE_LOAD, '0, '0, '0, 1'b1, '0, '0, '0, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First phase: the sender seldom idles and the receiver mostly stalls.
    send_gap_pct = 8;
    recv_gap_pct = 73;
    foreach (plan[k]) send_txn(plan[k].txn, plan[k].typed, plan[k].res);
    repeat (RANDOM_TXNS) send_txn(random_txn(), 1'b0, '0);
    settle_all();

    // Second phase: the roles are reversed. The sender waits for the queue to
    // drain before it starts again.
    send_gap_pct = 73;
    recv_gap_pct = 8;
    repeat (RANDOM_TXNS) send_txn(random_txn(), 1'b0, '0);
    settle_all();

    // Third phase: no idling at all, apart from the one long hold-off by the
    // receiver at its start.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_go      = 1'b1;
    repeat (RANDOM_TXNS) send_txn(random_txn(), 1'b0, '0);
    settle_all();

    // Anything still coming out after this point is flagged by the checker.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("planar_pose_composer_core regression: pass");
    end else begin
      $display("planar_pose_composer_core regression: fail");
    end
    $finish;
  end

endmodule
